/* rtl/core/cobs_pkg.sv */
// Shared types and constants for the COBS byte-stuffing encoder.
// Holds the result word layout and the fixed code values; no dependencies.
package cobs_pkg;

	localparam logic [7:0] CODE_ONE  = 8'h01;
	localparam logic [7:0] CODE_FULL = 8'hFF;
	localparam logic [7:0] DELIM     = 8'h00;

	// Number of result slots one input word can produce.
	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] out_offset;
		logic        is_last;
		logic        frame_done;
		logic [15:0] frame_length;
		logic        overflow;
	} res_t;

endpackage

/* rtl/core/cobs_byte_stuffing_encoder_top.sv */
// COBS byte-stuffing encoder, top level.
// Depends on cobs_pkg for the result word type and code constants.
//
// Usage: raw packet bytes enter on the input channel (in_valid / in_stall),
// one word per byte, with end_of_packet on the last byte and base_offset
// sampled on the first byte of each packet. Each output word
// (out_valid / out_stall) is one buffer write: a data byte, a block code
// back-filled into its reserved slot, or the zero delimiter that ends a
// frame together with frame_done and frame_length.
// An input word is captured in an input register, then turned combinationally
// into one to four output words that wait in a four-entry result shift
// register and leave one per cycle while out_stall is low. An output word
// passes the input register and then the result buffer. A byte that produces
// one output word sustains one byte per cycle without stalls; one with more
// words holds the output port until all have left, so the port sets the rate.
// Reset clears the frame state and empties both the input register and the
// result buffer. When the receiver stalls, the result buffer holds, the
// input register fills and in_stall rises; nothing is dropped.
module cobs_byte_stuffing_encoder_top #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic [15:0] base_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] out_offset,
	output logic        is_last,
	output logic        frame_done,
	output logic [15:0] frame_length,
	output logic        overflow
);

	localparam int P  = OFFSET_BITS;
	localparam int WB = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
	localparam int NR = cobs_pkg::MAX_RES;
	localparam int CW = $clog2(NR + 1);
	localparam int IW = $clog2(NR);

	// Input register.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eop_s1;
	logic [15:0] base_s1;

	// Frame state.
	logic [7:0]   code_q;
	logic [P-1:0] slot_q;
	logic [P-1:0] wp_q;
	logic [P-1:0] fs_q;
	logic         in_frame_q;
	logic         ovf_q;

	// Result buffer; entry 0 is presented on the output.
	cobs_pkg::res_t res_q [NR];
	logic [CW-1:0]  cnt_q;

	logic take;
	logic buf_free;
	logic load;
	logic accept;

	// Next-state and result values for the word in the input register.
	cobs_pkg::res_t res_d [NR];
	logic [CW-1:0]  n_d;
	logic [7:0]     code_d;
	logic [P-1:0]   slot_d;
	logic [P-1:0]   wp_d;
	logic [P-1:0]   fs_d;
	logic           in_frame_d;
	logic           ovf_d;

	function automatic logic [P:0] inc(input logic [P-1:0] p);
		inc = {1'b0, p} + {{P{1'b0}}, 1'b1};
	endfunction

	function automatic cobs_pkg::res_t mk(input logic [7:0] b, input logic [P-1:0] pos,
			input logic done, input logic [P-1:0] len, input logic ov);
		cobs_pkg::res_t r;
		r.out_byte     = b;
		r.out_offset   = 16'(pos);
		r.is_last      = 1'b0;
		r.frame_done   = done;
		r.frame_length = 16'(len);
		r.overflow     = ov;
		mk = r;
	endfunction

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && !out_stall;
	assign buf_free  = (cnt_q == '0) || ((cnt_q == CW'(1)) && take);
	assign load      = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !load;
	assign accept    = in_valid && !in_stall;

	assign out_byte     = res_q[0].out_byte;
	assign out_offset   = res_q[0].out_offset;
	assign is_last      = res_q[0].is_last;
	assign frame_done   = res_q[0].frame_done;
	assign frame_length = res_q[0].frame_length;
	assign overflow     = res_q[0].overflow;

	always_comb begin
		logic [WB-1:0] base_w;
		logic [P-1:0]  base_p;
		logic [P:0]    nx;
		logic [P-1:0]  delim;
		logic [P-1:0]  len;
		logic [CW-1:0] n;

		code_d     = code_q;
		slot_d     = slot_q;
		wp_d       = wp_q;
		fs_d       = fs_q;
		ovf_d      = ovf_q;
		in_frame_d = in_frame_q;
		n          = '0;
		nx         = '0;
		delim      = '0;
		len        = '0;
		for (int i = 0; i < NR; i++) begin
			res_d[i] = '0;
		end
		base_w = WB'(base_s1);
		base_p = P'(base_w);

		// The first byte of a frame places the first code slot at the base.
		if (!in_frame_q) begin
			ovf_d  = (WB'(base_p) != base_w);
			fs_d   = base_p;
			slot_d = base_p;
			nx     = inc(base_p);
			wp_d   = nx[P-1:0];
			ovf_d  = ovf_d | nx[P];
			code_d = cobs_pkg::CODE_ONE;
		end

		if (data_s1 == 8'h00) begin
			res_d[0] = mk(code_d, slot_d, 1'b0, '0, ovf_d);
			code_d   = cobs_pkg::CODE_ONE;
			slot_d   = wp_d;
			nx       = inc(wp_d);
			wp_d     = nx[P-1:0];
			ovf_d    = ovf_d | nx[P];
			n        = CW'(1);
		end else begin
			res_d[0] = mk(data_s1, wp_d, 1'b0, '0, ovf_d);
			nx       = inc(wp_d);
			wp_d     = nx[P-1:0];
			ovf_d    = ovf_d | nx[P];
			code_d   = code_d + 8'd1;
			n        = CW'(1);
			// A run of 254 nonzero bytes closes its block without a zero.
			if (code_d == cobs_pkg::CODE_FULL) begin
				res_d[1] = mk(code_d, slot_d, 1'b0, '0, ovf_d);
				code_d   = cobs_pkg::CODE_ONE;
				slot_d   = wp_d;
				nx       = inc(wp_d);
				wp_d     = nx[P-1:0];
				ovf_d    = ovf_d | nx[P];
				n        = CW'(2);
			end
		end

		if (eop_s1) begin
			res_d[n[IW-1:0]] = mk(code_d, slot_d, 1'b0, '0, ovf_d);
			n                = n + CW'(1);
			delim            = wp_d;
			nx               = inc(wp_d);
			wp_d             = nx[P-1:0];
			ovf_d            = ovf_d | nx[P];
			len              = wp_d - fs_d;
			res_d[n[IW-1:0]] = mk(cobs_pkg::DELIM, delim, 1'b1, len, ovf_d);
			n                = n + CW'(1);
			code_d           = cobs_pkg::CODE_ONE;
			in_frame_d       = 1'b0;
		end else begin
			in_frame_d = 1'b1;
		end

		res_d[IW'(n - CW'(1))].is_last = 1'b1;
		n_d = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			eop_s1  <= end_of_packet;
			base_s1 <= base_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q     <= cobs_pkg::CODE_ONE;
			slot_q     <= '0;
			wp_q       <= '0;
			fs_q       <= '0;
			in_frame_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (load) begin
			code_q     <= code_d;
			slot_q     <= slot_d;
			wp_q       <= wp_d;
			fs_q       <= fs_d;
			in_frame_q <= in_frame_d;
			ovf_q      <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_d;
		end else if (take) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NR; i++) begin
				res_q[i] <= res_d[i];
			end
		end else if (take) begin
			for (int i = 0; i < NR - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

endmodule
